### rtl/ohb_pkg.sv
`timescale 1ns / 1ps
package ohb_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int REQ_W      = 2;
   localparam int CSR_W      = 7;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DUMP  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic push;
      logic clear;
      logic dump_load;
      logic rd_step;
   } ohb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic rd_last;
   } ohb_status_type;

   // advance a ring index, wrapping at the configured capacity
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] sum;
      sum = {{(CNT_W-IDX_W){1'b0}}, idx} + CNT_W'(1);
      if (sum >= cap) begin
         return '0;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

### rtl/ohb_ctrl.sv
`timescale 1ns / 1ps
module ohb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ohb_pkg::REQ_W-1:0]  req_type,
   input  ohb_pkg::ohb_status_type    status,
   output ohb_pkg::ohb_cmd_type       cmd,
   output logic                       busy
);
   import ohb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_PUSH: begin
                     cmd.push = 1'b1;
                  end
                  REQ_DUMP: begin
                     // empty dump: drop the request, no results
                     if (!status.empty) begin
                        cmd.dump_load = 1'b1;
                        state_in      = ST_DUMP;
                     end
                  end
                  REQ_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            cmd.rd_step = 1'b1;
            if (status.rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/ohb_dpath.sv
`timescale 1ns / 1ps
module ohb_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ohb_pkg::ohb_cmd_type            cmd,
   input  logic [ohb_pkg::DATA_WIDTH-1:0]  data_in,
   input  logic                            csr_wr_en,
   input  logic [ohb_pkg::CSR_W-1:0]       csr_wr_data,
   output ohb_pkg::ohb_status_type         status,
   output logic                            rsp_strobe,
   output logic [ohb_pkg::DATA_WIDTH-1:0]  rsp_data,
   output logic                            rsp_last
);
   import ohb_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]      old_idx_ff, old_idx_in;
   logic                  full_ff, full_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]      remain_ff, remain_in;
   logic                  strobe_ff, strobe_in;
   logic                  last_ff, last_in;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [CNT_W-1:0]      csr_cap;
   logic [CNT_W-1:0]      fill_count;

   // clamp the written capacity into 1..DEPTH
   always_comb begin
      csr_cap = CNT_W'(csr_wr_data);
      if (csr_wr_data == '0) begin
         csr_cap = CNT_W'(1);
      end else if (CNT_W'(csr_wr_data) > CNT_W'(DEPTH)) begin
         csr_cap = CNT_W'(DEPTH);
      end
   end

   assign fill_count = full_ff ? cap_ff : {{(CNT_W-IDX_W){1'b0}}, wr_idx_ff};

   always_comb begin
      cap_in     = cap_ff;
      wr_idx_in  = wr_idx_ff;
      old_idx_in = old_idx_ff;
      full_in    = full_ff;
      rd_idx_in  = rd_idx_ff;
      remain_in  = remain_ff;
      strobe_in  = cmd.rd_step;
      last_in    = cmd.rd_step && (remain_ff == CNT_W'(1));
      if (csr_wr_en) begin
         cap_in     = csr_cap;
         wr_idx_in  = '0;
         old_idx_in = '0;
         full_in    = 1'b0;
      end else if (cmd.clear) begin
         wr_idx_in  = '0;
         old_idx_in = '0;
         full_in    = 1'b0;
      end else if (cmd.push) begin
         // when full, overwrite the oldest entry and advance past it
         if (full_ff) begin
            old_idx_in = next_idx(old_idx_ff, cap_ff);
         end
         wr_idx_in = next_idx(wr_idx_ff, cap_ff);
         full_in   = (wr_idx_in == old_idx_in);
      end else if (cmd.dump_load) begin
         rd_idx_in = old_idx_ff;
         remain_in = fill_count;
      end else if (cmd.rd_step) begin
         rd_idx_in = next_idx(rd_idx_ff, cap_ff);
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CNT_W'(DEPTH);
         wr_idx_ff  <= '0;
         old_idx_ff <= '0;
         full_ff    <= 1'b0;
         remain_ff  <= '0;
         strobe_ff  <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         wr_idx_ff  <= wr_idx_in;
         old_idx_ff <= old_idx_in;
         full_ff    <= full_in;
         remain_ff  <= remain_in;
         strobe_ff  <= strobe_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push && !csr_wr_en && !cmd.clear) begin
         mem[wr_idx_ff] <= data_in;
      end
      if (cmd.rd_step) begin
         rdata_ff <= mem[rd_idx_ff];
      end
   end

   assign status.empty   = !full_ff && (wr_idx_ff == '0);
   assign status.rd_last = (remain_ff == CNT_W'(1));

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rdata_ff;
   assign rsp_last   = last_ff;

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without a result strobe");

   a_step_has_work: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_step |-> (remain_ff != '0))
      else $error("dump read issued with no entries left");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ({{(CNT_W-IDX_W){1'b0}}, wr_idx_ff} < cap_ff)
      && ({{(CNT_W-IDX_W){1'b0}}, old_idx_ff} < cap_ff))
      else $error("ring index beyond capacity");

   a_full_meet: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wr_idx_ff == old_idx_ff))
      else $error("full buffer with head and tail apart");

   a_not_full_base: assert property (@(posedge clock) disable iff (reset)
      !full_ff |-> (old_idx_ff == '0))
      else $error("tail moved before the buffer filled");

endmodule

### rtl/overwriting_history_buffer_unit.sv
`timescale 1ns / 1ps
// Overwriting history buffer: keeps the most recent pushed words, up to the
// capacity set through the csr_ port (1..64; 0 acts as 1, larger values as 64).
// Writing the capacity empties the buffer.
//
// Request channel: a request is taken at a clock edge with start high and
// busy low. req_type selects push (store req_data_in at the head, overwriting
// the oldest entry once full), dump (stream all stored words oldest first)
// or clear (empty the buffer). Code 3 is ignored.
//
// Result channel: each dumped word sits on rsp_data_out for one cycle with
// rsp_strobe high; rsp_last marks the newest entry. The receiver cannot
// stall, so results are never held.
//
// Timing: busy never rises for push and clear, so pushes stream at one per
// cycle. A dump of N entries holds busy high while it reads them, one memory
// read per cycle on the single read port; the first result strobes once
// state_ff has entered ST_DUMP and the first read has been registered in
// rdata_ff and strobe_ff, one follows each cycle, and the newest entry shows in
// the first cycle with busy low. An empty dump yields nothing; busy stays low.
// Reset: synchronous, empties the buffer and sets capacity to 64.
module overwriting_history_buffer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ohb_pkg::REQ_W-1:0]       req_type,
   input  logic [ohb_pkg::DATA_WIDTH-1:0]  req_data_in,
   output logic                            rsp_strobe,
   output logic [ohb_pkg::DATA_WIDTH-1:0]  rsp_data_out,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [ohb_pkg::CSR_W-1:0]       csr_wr_data
);
   import ohb_pkg::*;

   ohb_cmd_type    cmd;
   ohb_status_type status;

   // sequence requests: decode, then walk the dump one entry per cycle
   ohb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // hold the ring indices, the entry store and the result registers
   ohb_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_in     (req_data_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data_out),
      .rsp_last    (rsp_last)
   );

endmodule
